@@ rtl/ecr_pkg.sv @@
// Shared types and constants for the quadrature encoder counter with speed reporting.
`timescale 1ns / 1ps
`default_nettype none

package ecr_pkg;

  // Default block dimensions
  localparam int CHANNELS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 8;

  // Fixed field widths
  localparam int PIN_W   = 4;
  localparam int CH_FLD_W = 2;
  localparam int CPR_W   = 16;

  // Arithmetic widths: numerator is |delta| * 60e6 (< 2^57), denominator cpr * elapsed (< 2^48)
  localparam int MUL_NUM_W = 57;
  localparam int DEN_W     = 48;
  localparam int QUO_W     = 32;

  localparam logic [25:0]      US_PER_MINUTE = 26'd60000000;
  localparam logic [CPR_W-1:0] CPR_RESET     = 16'd700;

  // Request operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [3:0]  pins_a;
    logic [3:0]  pins_b;
    logic [31:0] elapsed_us;
  } ecr_in_t;

  typedef struct packed {
    logic [1:0]         channel;
    logic signed [31:0] count_value;
    logic signed [31:0] speed_rpm;
    logic               last_channel;
  } ecr_out_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } ecr_div_res_t;

endpackage

`default_nettype wire

@@ rtl/encoder_counter_rpm.sv @@
// Top level: x1 quadrature encoder counters with per-channel speed reports.
// Usage:
//  - Input channel (in_valid / in_stall / in_data): a sample request carries the A and B
//    levels of every channel; a rising A edge steps that channel's count by +1 (B high)
//    or -1 (B low). Samples are taken one per cycle while in_stall is low, with no results.
//  - A report request carries elapsed microseconds and produces one result per channel
//    on the output channel (out_valid / out_stall / out_data), channel 0 first, with
//    last_channel set on the final one. The counts then become the new reference.
//    A report with zero elapsed time is dropped and changes nothing.
//  - During a report each channel runs one pass of the shared multiplier and then the
//    bit-serial divider, one quotient bit per cycle over 57 + FRAC_BITS dividend bits.
//    A channel with no movement, or a zero counts_per_rev, skips the divider. in_stall
//    is high throughout.
//  - The output register holds a result until it is taken; while out_stall is high the
//    sequencer waits with the next result and the payload holds.
//  - cfg_valid / cfg_ready writes counts_per_rev; cfg_ready is always high. Write it only
//    while no report is in flight. Zero forces speed to zero.
//  - Synchronous reset clears all counts, references and A history, loads
//    counts_per_rev with 700 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module encoder_counter_rpm #(
  parameter int CHANNELS  = ecr_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS = ecr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire ecr_pkg::ecr_in_t           in_data,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      ecr_pkg::ecr_out_t          out_data,
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic [ecr_pkg::CPR_W-1:0]  cfg_data
);
  import ecr_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NUM_W = MUL_NUM_W + FRAC_BITS;
  localparam int EXT_W = CHANNELS + PIN_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MDEN   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_MNUM   = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]           state_r;
  logic [CH_W-1:0]      ch_r;
  logic [CPR_W-1:0]     cpr_r;
  logic [31:0]          elapsed_r;
  logic [31:0]          tick_r [CHANNELS];
  logic [31:0]          last_r [CHANNELS];
  logic [CHANNELS-1:0]  prev_a_r;
  logic [DEN_W-1:0]     den_r;
  logic [MUL_NUM_W-1:0] num_r;
  logic [31:0]          mag_r;
  logic                 neg_r;
  logic [31:0]          count_r;
  logic [31:0]          speed_r;
  logic                 out_valid_r;
  ecr_out_t             out_r;

  logic                 in_acc;
  logic                 out_load;
  logic                 last_ch;
  logic [EXT_W-1:0]     pa_ext;
  logic [EXT_W-1:0]     pb_ext;
  logic [31:0]          delta;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          mul_p;
  logic                 div_start;
  ecr_div_res_t         div_res;
  logic [31:0]          limit;
  logic [31:0]          mag_sat;
  logic [31:0]          speed_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign last_ch   = (ch_r == CH_W'(CHANNELS - 1));
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Widen the pin fields so channels beyond the pin width read as low
  assign pa_ext = EXT_W'(in_data.pins_a);
  assign pb_ext = EXT_W'(in_data.pins_b);

  // Hold counts_per_rev
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r <= CPR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cpr_r <= cfg_data;
    end
  end

  // Count rising A edges and advance the report reference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        tick_r[i] <= '0;
        last_r[i] <= '0;
      end
    end else begin
      if (in_acc && in_data.operation == OP_SAMPLE) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (pa_ext[i] && !prev_a_r[i]) begin
            tick_r[i] <= pb_ext[i] ? tick_r[i] + 32'd1 : tick_r[i] - 32'd1;
          end
          prev_a_r[i] <= pa_ext[i];
        end
      end
      if (state_r == S_LOAD) begin
        last_r[ch_r] <= tick_r[ch_r];
      end
    end
  end

  // Signed count difference since the last report
  assign delta = tick_r[ch_r] - last_r[ch_r];

  // Shared multiplier: denominator first, then numerator per channel
  always_comb begin
    if (state_r == S_MDEN) begin
      mul_a = 32'(cpr_r);
      mul_b = elapsed_r;
    end else begin
      mul_a = mag_r;
      mul_b = 32'(US_PER_MINUTE);
    end
    mul_p = mul_a * mul_b;
  end

  assign div_start = (state_r == S_DSTART) && (den_r != '0) && (num_r != '0);

  ecr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (NUM_W'(num_r) << FRAC_BITS),
    .den   (den_r),
    .res   (div_res)
  );

  // Saturate the magnitude and restore the sign
  always_comb begin
    limit     = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag_sat   = (div_res.ovf || (div_res.quo > limit)) ? limit : div_res.quo;
    speed_nxt = neg_r ? (~mag_sat + 32'd1) : mag_sat;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_data.operation == OP_REPORT && in_data.elapsed_us != '0) begin
            ch_r    <= '0;
            state_r <= S_MDEN;
          end
        end
        S_MDEN:   state_r <= S_LOAD;
        S_LOAD:   state_r <= S_MNUM;
        S_MNUM:   state_r <= S_DSTART;
        S_DSTART: state_r <= div_start ? S_DWAIT : S_OUT;
        S_DWAIT: begin
          if (div_res.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (last_ch) begin
              state_r <= S_IDLE;
            end else begin
              ch_r    <= ch_r + CH_W'(1);
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers for the channel in work
  always_ff @(posedge clk) begin
    if (in_acc) begin
      elapsed_r <= in_data.elapsed_us;
    end
    if (state_r == S_MDEN) begin
      den_r <= mul_p[DEN_W-1:0];
    end
    if (state_r == S_LOAD) begin
      count_r <= tick_r[ch_r];
      neg_r   <= delta[31];
      mag_r   <= delta[31] ? (~delta + 32'd1) : delta;
    end
    if (state_r == S_MNUM) begin
      num_r <= mul_p[MUL_NUM_W-1:0];
    end
    if (state_r == S_DSTART && !div_start) begin
      speed_r <= '0;
    end else if (state_r == S_DWAIT && div_res.done) begin
      speed_r <= speed_nxt;
    end
  end

  // Output register: load a result, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.channel      <= CH_FLD_W'(ch_r);
      out_r.count_value  <= count_r;
      out_r.speed_rpm    <= speed_r;
      out_r.last_channel <= last_ch;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ rtl/ecr_div.sv @@
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module ecr_div #(
  parameter int NUM_W = ecr_pkg::MUL_NUM_W + ecr_pkg::FRAC_BITS_DEF,
  parameter int DEN_W = ecr_pkg::DEN_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [NUM_W-1:0]     num,
  input  wire logic [DEN_W-1:0]     den,
  output ecr_pkg::ecr_div_res_t     res
);
  import ecr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // Control: start, count down steps, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, keep the remainder below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= num_r << 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
      ovf_r <= ovf_r | quo_r[QUO_W-1];
    end
  end

  assign res = {done_r, ovf_r, quo_r};

endmodule

`default_nettype wire
